### rtl/core/bbf_pkg.sv
// Shared types and constants for the bounded byte FIFO.
package bbf_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 13;
    localparam int TOT_W  = 64;
    localparam int MODE_W = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_CLOSE,
        OP_NOP
    } t_op;

    typedef enum logic {
        BK_EXEC,
        BK_READ
    } t_back_state;

    // classified command, front to back
    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic              accepted;
        logic [BYTE_W-1:0] front_byte;
        logic              front_valid;
        logic [CNT_W-1:0]  free_space;
        logic [CNT_W-1:0]  buffered_count;
        logic [TOT_W-1:0]  total_pushed;
        logic [TOT_W-1:0]  total_popped;
        logic              closed;
        logic              finished;
    } t_result;

endpackage

### rtl/core/bbf_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module bbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bbf_front.sv
// Front end: accepts input beats, decodes the mode, and queues commands for the back end.
module bbf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [bbf_pkg::MODE_W-1:0]  i_mode,
    input  logic [bbf_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic [bbf_pkg::CNT_W-1:0]   i_pop_count,
    output logic                        o_full,
    output logic                        o_cmd_valid,
    output bbf_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_take
);

    logic [1:0]    r_count, n_count;
    logic          r_wr_idx, n_wr_idx;
    logic          r_rd_idx, n_rd_idx;
    bbf_pkg::t_cmd r_q [2];
    bbf_pkg::t_cmd dec_cmd;
    logic          wr_en;
    logic          rd_en;

    // mode decode
    always_comb begin
        dec_cmd.data  = i_data_byte;
        dec_cmd.count = i_pop_count;
        unique case (i_mode)
            bbf_pkg::MODE_PUSH:  dec_cmd.op = bbf_pkg::OP_PUSH;
            bbf_pkg::MODE_POP:   dec_cmd.op = bbf_pkg::OP_POP;
            bbf_pkg::MODE_CLOSE: dec_cmd.op = bbf_pkg::OP_CLOSE;
            bbf_pkg::MODE_NOP:   dec_cmd.op = bbf_pkg::OP_NOP;
            default:             dec_cmd.op = bbf_pkg::OP_NOP;
        endcase
    end

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_idx];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_wr_idx = wr_en ? !r_wr_idx : r_wr_idx;
        n_rd_idx = rd_en ? !r_rd_idx : r_rd_idx;
        n_count  = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 2'd1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_idx] <= dec_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd3))
        else $error("command queue count out of range");

    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) && !wr_en |=> (r_count == 2'd0))
        else $error("command queue count moved with no beat");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !rd_en |=> o_full)
        else $error("command queue left full with no take");

endmodule

### rtl/core/bbf_back.sv
// Back end: executes queued commands on the byte store and holds the result beat.
module bbf_back #(
    parameter int DEPTH = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  bbf_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_take,
    input  logic                       i_cfg_valid,
    input  logic [bbf_pkg::CNT_W-1:0]  i_cfg_capacity,
    output logic                       o_res_valid,
    output bbf_pkg::t_result           o_res,
    input  logic                       i_res_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int SW = ((PW > bbf_pkg::CNT_W) ? PW : bbf_pkg::CNT_W) + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

    bbf_pkg::t_back_state r_state, n_state;

    logic [PW-1:0]              r_rp, n_rp;
    logic [PW-1:0]              r_wp, n_wp;
    logic [bbf_pkg::CNT_W-1:0]  r_occ, n_occ;
    logic                       r_closed, n_closed;
    logic [bbf_pkg::TOT_W-1:0]  r_pushed, n_pushed;
    logic [bbf_pkg::TOT_W-1:0]  r_popped, n_popped;
    logic [bbf_pkg::CNT_W-1:0]  r_capacity;
    logic                       r_acc, n_acc;
    logic                       r_bypass, n_bypass;
    logic [bbf_pkg::BYTE_W-1:0] r_bypass_byte;
    logic                       r_res_valid;
    bbf_pkg::t_result           r_res, res_next;

    logic [bbf_pkg::CNT_W-1:0]  cap;
    logic [bbf_pkg::CNT_W-1:0]  pop_n;
    logic [SW-1:0]              rp_sum;
    logic                       push_ok;
    logic                       mem_we;
    logic                       cmd_take;
    logic                       res_load;
    logic [bbf_pkg::BYTE_W-1:0] rdata;

    // effective capacity saturates at the store depth
    assign cap = (SW'(r_capacity) > DEPTH_S) ? bbf_pkg::CNT_W'(DEPTH) : r_capacity;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbf_pkg::BK_EXEC: if (i_cmd_valid) n_state = bbf_pkg::BK_READ;
            bbf_pkg::BK_READ: if (!r_res_valid || i_res_pop) n_state = bbf_pkg::BK_EXEC;
            default:          n_state = bbf_pkg::BK_EXEC;
        endcase
    end

    // FSM outputs
    always_comb begin
        cmd_take = 1'b0;
        res_load = 1'b0;
        unique case (r_state)
            bbf_pkg::BK_EXEC: cmd_take = i_cmd_valid;
            bbf_pkg::BK_READ: res_load = !r_res_valid || i_res_pop;
            default: begin
                cmd_take = 1'b0;
                res_load = 1'b0;
            end
        endcase
    end

    assign o_cmd_take = cmd_take;

    // command execution
    always_comb begin
        push_ok  = (i_cmd.op == bbf_pkg::OP_PUSH) && (r_occ < cap);
        pop_n    = (i_cmd.count > r_occ) ? r_occ : i_cmd.count;
        rp_sum   = SW'(r_rp) + SW'(pop_n);
        if (rp_sum >= DEPTH_S) begin
            rp_sum = rp_sum - DEPTH_S;
        end
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_occ    = r_occ;
        n_closed = r_closed;
        n_pushed = r_pushed;
        n_popped = r_popped;
        n_acc    = 1'b0;
        // a push into an empty store makes the new byte the front
        n_bypass = push_ok && (r_occ == '0);
        case (i_cmd.op)
            bbf_pkg::OP_PUSH: begin
                if (push_ok) begin
                    n_wp     = (r_wp == LAST_P) ? '0 : r_wp + PW'(1);
                    n_occ    = r_occ + bbf_pkg::CNT_W'(1);
                    n_pushed = r_pushed + bbf_pkg::TOT_W'(1);
                    n_acc    = 1'b1;
                end
            end
            bbf_pkg::OP_POP: begin
                n_rp     = rp_sum[PW-1:0];
                n_occ    = r_occ - pop_n;
                n_popped = r_popped + bbf_pkg::TOT_W'(pop_n);
            end
            bbf_pkg::OP_CLOSE: n_closed = 1'b1;
            default: ;
        endcase
    end

    assign mem_we = cmd_take && push_ok;

    bbf_ram #(
        .WIDTH (bbf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (i_cmd.data),
        .i_re    (cmd_take),
        .i_raddr (n_rp),
        .o_rdata (rdata)
    );

    // result assembly from post-operation state
    always_comb begin
        res_next.accepted       = r_acc;
        res_next.front_valid    = (r_occ != '0);
        res_next.front_byte     = (r_occ == '0) ? '0 : (r_bypass ? r_bypass_byte : rdata);
        res_next.free_space     = (cap > r_occ) ? cap - r_occ : '0;
        res_next.buffered_count = r_occ;
        res_next.total_pushed   = r_pushed;
        res_next.total_popped   = r_popped;
        res_next.closed         = r_closed;
        res_next.finished       = r_closed && (r_occ == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbf_pkg::BK_EXEC;
            r_rp        <= '0;
            r_wp        <= '0;
            r_occ       <= '0;
            r_closed    <= 1'b0;
            r_pushed    <= '0;
            r_popped    <= '0;
            r_capacity  <= bbf_pkg::CAP_RESET;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd_take) begin
                r_rp     <= n_rp;
                r_wp     <= n_wp;
                r_occ    <= n_occ;
                r_closed <= n_closed;
                r_pushed <= n_pushed;
                r_popped <= n_popped;
            end
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_capacity;
            end
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take) begin
            r_acc         <= n_acc;
            r_bypass      <= n_bypass;
            r_bypass_byte <= i_cmd.data;
        end
        if (res_load) begin
            r_res <= res_next;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // pointer distance must agree with occupancy
    logic [SW-1:0] ptr_gap;
    always_comb begin
        ptr_gap = SW'(r_wp) + DEPTH_S - SW'(r_rp);
        if (ptr_gap >= DEPTH_S) begin
            ptr_gap = ptr_gap - DEPTH_S;
        end
    end

    a_ptr_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_occ) == ptr_gap) || (SW'(r_occ) == DEPTH_S && ptr_gap == '0))
        else $error("pointer gap disagrees with occupancy");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_occ) <= DEPTH_S)
        else $error("occupancy beyond store depth");

    a_take_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |=> (r_state == bbf_pkg::BK_READ))
        else $error("command taken without a read cycle");

    a_push_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_pushed == $past(r_pushed) + bbf_pkg::TOT_W'(1)))
        else $error("stored byte not counted");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !i_res_pop |=> r_res_valid)
        else $error("result beat dropped before pop");

endmodule

### rtl/core/bounded_byte_fifo.sv
// Bounded byte FIFO top level: front decoder, command queue, back executor.
// Each accepted beat goes into the command queue; the back end takes one command, updates its state,
//   reads the byte store and loads the result beat (empty low) before it takes the next,
//   stalling while a result is unpopped; full rises when the 2-entry command queue fills.
// Reset (synchronous, active low): pointers, occupancy, totals and close flag clear,
//   capacity returns to 4096; the byte store itself is not cleared and needs no pass.
module bounded_byte_fifo #(
    parameter int DEPTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input side
    input  logic                        push,
    output logic                        full,
    input  logic [bbf_pkg::MODE_W-1:0]  i_mode,
    input  logic [bbf_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic [bbf_pkg::CNT_W-1:0]   i_pop_count,
    // result side
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_accepted,
    output logic [bbf_pkg::BYTE_W-1:0]  o_front_byte,
    output logic                        o_front_valid,
    output logic [bbf_pkg::CNT_W-1:0]   o_free_space,
    output logic [bbf_pkg::CNT_W-1:0]   o_buffered_count,
    output logic [bbf_pkg::TOT_W-1:0]   o_total_pushed,
    output logic [bbf_pkg::TOT_W-1:0]   o_total_popped,
    output logic                        o_closed,
    output logic                        o_finished,
    // capacity register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bbf_pkg::CNT_W-1:0]   i_cfg_capacity
);

    logic             cmd_valid;
    logic             cmd_take;
    bbf_pkg::t_cmd    cmd;
    logic             res_valid;
    bbf_pkg::t_result res;

    // front: decode mode, buffer up to two commands
    bbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .i_pop_count (i_pop_count),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // back: update pointers and totals, read the front byte, hold the result beat
    bbf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_take     (cmd_take),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_capacity (i_cfg_capacity),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_res_pop      (pop)
    );

    // capacity is a plain register, always writable
    assign o_cfg_ready = 1'b1;

    assign empty            = !res_valid;
    assign o_accepted       = res.accepted;
    assign o_front_byte     = res.front_byte;
    assign o_front_valid    = res.front_valid;
    assign o_free_space     = res.free_space;
    assign o_buffered_count = res.buffered_count;
    assign o_total_pushed   = res.total_pushed;
    assign o_total_popped   = res.total_popped;
    assign o_closed         = res.closed;
    assign o_finished       = res.finished;

endmodule

### dv/tb.sv
// Self-checking testbench for bounded_byte_fifo: directed table walk, then random phases.
module tb;

    localparam int STORE_DEPTH = 4096;
    localparam int HOLD_CYCLES = 150;   // long receiver hold-off, fills the command queue
    localparam int END_WAIT    = 8;     // settling wait once no status is owed
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_OPS   = 80;
    localparam int N_PHASES    = 12;
    localparam int PRESS_PHASE = 4;

    typedef enum logic {
        ROW_OP,
        ROW_CAP
    } t_row_kind;

    // one line of the directed table: an operation, or a capacity write
    typedef struct {
        t_row_kind                  kind;
        logic [bbf_pkg::MODE_W-1:0] mode;
        logic [bbf_pkg::BYTE_W-1:0] data;
        logic [bbf_pkg::CNT_W-1:0]  count;
        bit                         typed;   // status below is written out by hand
        bbf_pkg::t_result           status;
    } t_row;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        push           = 1'b0;
    logic                        full;
    logic [bbf_pkg::MODE_W-1:0]  i_mode         = bbf_pkg::MODE_NOP;
    logic [bbf_pkg::BYTE_W-1:0]  i_data_byte    = '0;
    logic [bbf_pkg::CNT_W-1:0]   i_pop_count    = '0;
    logic                        empty;
    logic                        pop            = 1'b0;
    logic                        o_accepted;
    logic [bbf_pkg::BYTE_W-1:0]  o_front_byte;
    logic                        o_front_valid;
    logic [bbf_pkg::CNT_W-1:0]   o_free_space;
    logic [bbf_pkg::CNT_W-1:0]   o_buffered_count;
    logic [bbf_pkg::TOT_W-1:0]   o_total_pushed;
    logic [bbf_pkg::TOT_W-1:0]   o_total_popped;
    logic                        o_closed;
    logic                        o_finished;
    logic                        i_cfg_valid    = 1'b0;
    logic                        o_cfg_ready;
    logic [bbf_pkg::CNT_W-1:0]   i_cfg_capacity = bbf_pkg::CAP_RESET;

    always #10 i_clk = ~i_clk;

    bounded_byte_fifo #(
        .DEPTH(STORE_DEPTH)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_mode           (i_mode),
        .i_data_byte      (i_data_byte),
        .i_pop_count      (i_pop_count),
        .empty            (empty),
        .pop              (pop),
        .o_accepted       (o_accepted),
        .o_front_byte     (o_front_byte),
        .o_front_valid    (o_front_valid),
        .o_free_space     (o_free_space),
        .o_buffered_count (o_buffered_count),
        .o_total_pushed   (o_total_pushed),
        .o_total_popped   (o_total_popped),
        .o_closed         (o_closed),
        .o_finished       (o_finished),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_capacity   (i_cfg_capacity)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the queue: byte store, pointers, counters, capacity.
    // ------------------------------------------------------------------
    logic [bbf_pkg::BYTE_W-1:0] sh_store [STORE_DEPTH];
    logic [11:0]                sh_rd;
    logic [11:0]                sh_wr;
    logic [bbf_pkg::CNT_W-1:0]  sh_occ;
    logic [bbf_pkg::CNT_W-1:0]  sh_cap;
    logic                       sh_closed;
    logic [bbf_pkg::TOT_W-1:0]  sh_pushed;
    logic [bbf_pkg::TOT_W-1:0]  sh_popped;

    bbf_pkg::t_result status_q [$];      // statuses owed by the block, oldest first
    t_row             dir_rows [$];

    int  n_errors     = 0;
    int  n_ops        = 0;
    int  n_checked    = 0;
    int  n_cap_writes = 0;
    int  n_dropped    = 0;
    int  n_full_waits = 0;
    int  peak_occ     = 0;
    int  n_cycles     = 0;
    bit  tx_calm      = 1'b0;   // sender never idles
    bit  rx_calm      = 1'b0;   // receiver never idles
    bit  hold_req     = 1'b0;   // sender asks the receiver for a long hold-off

    // Apply one operation to the shadow queue and return the status it leaves.
    function automatic bbf_pkg::t_result fifo_apply(
            input logic [bbf_pkg::MODE_W-1:0] mode,
            input logic [bbf_pkg::BYTE_W-1:0] data,
            input logic [bbf_pkg::CNT_W-1:0]  count);
        logic [bbf_pkg::CNT_W-1:0] lim;
        logic [bbf_pkg::CNT_W-1:0] take;
        bbf_pkg::t_result          r;
        // capacity beyond the store depth saturates
        lim = (sh_cap > bbf_pkg::CNT_W'(STORE_DEPTH)) ? bbf_pkg::CNT_W'(STORE_DEPTH) : sh_cap;
        r   = '0;
        case (mode)
            bbf_pkg::MODE_PUSH: begin
                if (sh_occ < lim) begin
                    sh_store[sh_wr] = data;
                    sh_wr           = sh_wr + 12'd1;
                    sh_occ          = sh_occ + bbf_pkg::CNT_W'(1);
                    sh_pushed       = sh_pushed + bbf_pkg::TOT_W'(1);
                    r.accepted      = 1'b1;
                end else begin
                    n_dropped++;
                end
            end
            bbf_pkg::MODE_POP: begin
                // clamp to what is buffered; 4096 wraps the 12-bit pointer exactly
                take      = (count > sh_occ) ? sh_occ : count;
                sh_rd     = sh_rd + take[11:0];
                sh_occ    = sh_occ - take;
                sh_popped = sh_popped + bbf_pkg::TOT_W'(take);
            end
            bbf_pkg::MODE_CLOSE: begin
                sh_closed = 1'b1;
            end
            default: ;
        endcase
        r.front_valid    = (sh_occ != '0);
        r.front_byte     = (sh_occ != '0) ? sh_store[sh_rd] : '0;
        // free space floors at zero when capacity was lowered under occupancy
        r.free_space     = (lim > sh_occ) ? lim - sh_occ : '0;
        r.buffered_count = sh_occ;
        r.total_pushed   = sh_pushed;
        r.total_popped   = sh_popped;
        r.closed         = sh_closed;
        r.finished       = sh_closed && (sh_occ == '0);
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap(input bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic note_mismatch(input string what);
        n_errors++;
        $display("MISMATCH at cycle %0d, status beat %0d: %s", n_cycles, n_checked, what);
    endtask

    task automatic cmp_field(input string name, input logic [bbf_pkg::TOT_W-1:0] got,
                             input logic [bbf_pkg::TOT_W-1:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Table builders.
    task automatic add_op(input logic [bbf_pkg::MODE_W-1:0] mode,
                          input logic [bbf_pkg::BYTE_W-1:0] data,
                          input logic [bbf_pkg::CNT_W-1:0]  count);
        t_row row;
        row = '{ROW_OP, mode, data, count, 1'b0, '0};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic add_op_chk(input logic [bbf_pkg::MODE_W-1:0] mode,
                              input logic [bbf_pkg::BYTE_W-1:0] data,
                              input logic [bbf_pkg::CNT_W-1:0]  count,
                              input bbf_pkg::t_result           status);
        t_row row;
        row = '{ROW_OP, mode, data, count, 1'b1, status};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic add_cap(input logic [bbf_pkg::CNT_W-1:0] value);
        t_row row;
        row = '{ROW_CAP, bbf_pkg::MODE_NOP, '0, value, 1'b0, '0};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Offer one beat; hold it until the block takes it, then log what it owes.
    task automatic offer(input logic [bbf_pkg::MODE_W-1:0] mode,
                         input logic [bbf_pkg::BYTE_W-1:0] data,
                         input logic [bbf_pkg::CNT_W-1:0]  count, input bit typed,
                         input bbf_pkg::t_result           typed_status);
        int               gap;
        bbf_pkg::t_result pred;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_mode      <= mode;
        i_data_byte <= data;
        i_pop_count <= count;
        do begin
            @(posedge i_clk);
            if (full)
                n_full_waits++;
        end while (full);
        pred = fifo_apply(mode, data, count);
        status_q.insert(status_q.size(), typed ? typed_status : pred);
        n_ops++;
    endtask

    // Capacity write: only once every owed status has come back.
    task automatic set_capacity(input logic [bbf_pkg::CNT_W-1:0] value);
        push <= 1'b0;
        while (status_q.size() != 0)
            @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_capacity <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sh_cap = value;
        n_cap_writes++;
    endtask

    // ------------------------------------------------------------------
    // Watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d statuses still owed",
                     n_cycles, status_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: take status beats with random pop gaps, compare each
    // against the oldest owed status. A hold request parks pop low for
    // HOLD_CYCLES so the block backs up into its input.
    // ------------------------------------------------------------------
    initial begin : status_drain
        int               rx_wait;
        bbf_pkg::t_result got;
        bbf_pkg::t_result want;
        rx_wait = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got = '{o_accepted, o_front_byte, o_front_valid, o_free_space,
                        o_buffered_count, o_total_pushed, o_total_popped,
                        o_closed, o_finished};
                if (status_q.size() == 0) begin
                    note_mismatch("status beat with nothing owed");
                end else begin
                    want = status_q[0];
                    status_q.delete(0);
                    cmp_field("accepted", bbf_pkg::TOT_W'(got.accepted),
                              bbf_pkg::TOT_W'(want.accepted));
                    cmp_field("front_byte", bbf_pkg::TOT_W'(got.front_byte),
                              bbf_pkg::TOT_W'(want.front_byte));
                    cmp_field("front_valid", bbf_pkg::TOT_W'(got.front_valid),
                              bbf_pkg::TOT_W'(want.front_valid));
                    cmp_field("free_space", bbf_pkg::TOT_W'(got.free_space),
                              bbf_pkg::TOT_W'(want.free_space));
                    cmp_field("buffered_count", bbf_pkg::TOT_W'(got.buffered_count),
                              bbf_pkg::TOT_W'(want.buffered_count));
                    cmp_field("total_pushed", got.total_pushed, want.total_pushed);
                    cmp_field("total_popped", got.total_popped, want.total_popped);
                    cmp_field("closed", bbf_pkg::TOT_W'(got.closed),
                              bbf_pkg::TOT_W'(want.closed));
                    cmp_field("finished", bbf_pkg::TOT_W'(got.finished),
                              bbf_pkg::TOT_W'(want.finished));
                    if (int'(want.buffered_count) > peak_occ)
                        peak_occ = int'(want.buffered_count);
                    n_checked++;
                end
                rx_wait = pick_gap(rx_calm);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                rx_wait  = HOLD_CYCLES;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, random phases, drain, verdict.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [bbf_pkg::CNT_W-1:0]  phase_caps [N_PHASES];
        logic [bbf_pkg::MODE_W-1:0] m;
        logic [bbf_pkg::CNT_W-1:0]  c;
        int                         roll;
        int                         push_pct;

        sh_rd     = '0;
        sh_wr     = '0;
        sh_occ    = '0;
        sh_cap    = bbf_pkg::CAP_RESET;
        sh_closed = 1'b0;
        sh_pushed = '0;
        sh_popped = '0;

        // Directed table. Hand-written statuses: the reset state, the empty
        // pop, the first pushes, a drain to zero under capacity 0, and the
        // finished state after close.
        add_op_chk(bbf_pkg::MODE_NOP,  8'h00, 13'd0,
                   '{1'b0, 8'h00, 1'b0, 13'd4096, 13'd0, 64'd0, 64'd0, 1'b0, 1'b0});
        add_op_chk(bbf_pkg::MODE_POP,  8'h00, 13'd8191,
                   '{1'b0, 8'h00, 1'b0, 13'd4096, 13'd0, 64'd0, 64'd0, 1'b0, 1'b0});
        add_op_chk(bbf_pkg::MODE_PUSH, 8'hFF, 13'd0,
                   '{1'b1, 8'hFF, 1'b1, 13'd4095, 13'd1, 64'd1, 64'd0, 1'b0, 1'b0});
        add_op_chk(bbf_pkg::MODE_PUSH, 8'h00, 13'd8191,
                   '{1'b1, 8'hFF, 1'b1, 13'd4094, 13'd2, 64'd2, 64'd0, 1'b0, 1'b0});
        add_op(bbf_pkg::MODE_PUSH, 8'hA5, 13'd0);
        add_op(bbf_pkg::MODE_POP,  8'hFF, 13'd1);
        add_op(bbf_pkg::MODE_POP,  8'h00, 13'd0);
        add_cap(13'd1);                                 // capacity now under occupancy
        add_op(bbf_pkg::MODE_PUSH, 8'h3C, 13'd0);       // dropped, free space floors at 0
        add_op(bbf_pkg::MODE_POP,  8'h00, 13'd1);
        add_op(bbf_pkg::MODE_PUSH, 8'hC3, 13'd0);       // still at capacity, dropped
        add_cap(13'd0);
        add_op(bbf_pkg::MODE_PUSH, 8'h7E, 13'd0);       // zero capacity drops everything
        add_op_chk(bbf_pkg::MODE_POP,  8'h00, 13'd8191,
                   '{1'b0, 8'h00, 1'b0, 13'd0, 13'd0, 64'd3, 64'd3, 1'b0, 1'b0});
        add_cap(13'd8191);                              // saturates at the store depth
        add_op(bbf_pkg::MODE_PUSH, 8'h55, 13'd0);
        add_op(bbf_pkg::MODE_CLOSE, 8'h00, 13'd0);
        add_op(bbf_pkg::MODE_CLOSE, 8'hFF, 13'd8191);   // second close changes nothing
        add_op(bbf_pkg::MODE_PUSH, 8'hAA, 13'd0);       // close does not block pushes
        add_op_chk(bbf_pkg::MODE_POP,  8'h00, 13'd4096,
                   '{1'b0, 8'h00, 1'b0, 13'd4096, 13'd0, 64'd5, 64'd5, 1'b1, 1'b1});
        add_op(bbf_pkg::MODE_NOP,  8'h5A, 13'd4096);
        add_cap(13'd4096);

        phase_caps = '{13'd2, 13'd16, 13'd0, 13'd5, 13'd8191, 13'd1,
                       13'd40, 13'd3, 13'd4095, 13'd8, 13'd7, 13'd6000};
        phase_caps[9] = bbf_pkg::CNT_W'($urandom_range(8, 64));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CAP)
                set_capacity(dir_rows[i].count);
            else
                offer(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].count,
                      dir_rows[i].typed, dir_rows[i].status);
        end

        // Random phases, one capacity each. The phase order lets large
        // occupancies meet a smaller capacity afterwards.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_capacity(phase_caps[ph]);
            tx_calm  = ($urandom_range(0, 3) == 0);
            rx_calm  = ($urandom_range(0, 3) == 0);
            push_pct = $urandom_range(40, 85);
            if (ph == PRESS_PHASE) begin
                // receiver stalls while the sender keeps the input busy
                tx_calm  = 1'b1;
                push_pct = 90;
                hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_OPS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct)
                    m = bbf_pkg::MODE_PUSH;
                else if (roll < 96)
                    m = bbf_pkg::MODE_POP;
                else if (roll < 99)
                    m = bbf_pkg::MODE_NOP;
                else
                    m = bbf_pkg::MODE_CLOSE;
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    c = bbf_pkg::CNT_W'($urandom_range(0, 3));
                else if (roll < 80)
                    c = bbf_pkg::CNT_W'($urandom_range(0, int'(sh_occ) + 2));
                else if (roll < 90)
                    c = bbf_pkg::CNT_W'($urandom_range(0, 8191));
                else if (roll < 95)
                    c = sh_occ;
                else
                    c = 13'd4096;
                offer(m, bbf_pkg::BYTE_W'($urandom), c, 1'b0, '0);
            end
        end

        push <= 1'b0;
        while (status_q.size() != 0)
            @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);

        $display("run: %0d ops, %0d status beats checked, %0d capacity writes",
                 n_ops, n_checked, n_cap_writes);
        $display("run: %0d pushes dropped, peak occupancy %0d, %0d cycles held by full",
                 n_dropped, peak_occ, n_full_waits);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
